>>> hdl/erfc_pkg.sv
// Shared types and constants for the encoder reply frame checker.
// No dependencies; every other file in hdl imports this package.
package erfc_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 19;
  localparam int unsigned POS_W = 5;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [POS_W-1:0] POS_ANGLE_HI = 5'd3;
  localparam logic [POS_W-1:0] POS_ANGLE_LO = 5'd4;
  localparam logic [POS_W-1:0] POS_DIR      = 5'd16;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic        crc_bad;
    logic [15:0] angle_raw;
    logic [7:0]  direction;
  } out_t;

endpackage

>>> hdl/encoder_reply_frame_checker_unit.sv
// Encoder reply frame checker: frame tracking, CRC-16 check and output register.
// Depends on erfc_pkg and erfc_crc16_byte.
//
// The block takes one reply byte per request on the input channel and gives one
// result per completed frame of FRAME_BYTES bytes: the CRC verdict (received CRC
// in the last two bytes, low byte first, against a Modbus-style CRC-16 over the
// bytes before them), the angle word from bytes 3 and 4 and the direction from
// byte 16 (zero if the frame is shorter). frame_start on a byte drops any partial
// frame and takes that byte as byte 0; after the last byte a new frame begins by
// itself. The CRC byte update sits between the frame state registers and its
// next value, and the result appears in the output register the cycle after the
// last byte is accepted. Input is held off only while the frame position sits at
// the last byte and the previous result is still waiting in the output register;
// a frame_start byte offered then waits too.
module encoder_reply_frame_checker_unit #(
  parameter int unsigned FRAME_BYTES = erfc_pkg::FRAME_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  erfc_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output erfc_pkg::out_t out_data_o
);
  import erfc_pkg::*;

  localparam logic [POS_W-1:0] LastPos  = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] CrcLoPos = POS_W'(FRAME_BYTES - 2);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      crc_q, crc_d;
  logic [15:0]      angle_q, angle_d;
  logic [7:0]       dir_q, dir_d;
  logic [7:0]       crc_lo_q, crc_lo_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_data_q, out_data_d;

  logic [POS_W-1:0] pos_cur;
  logic [15:0]      crc_cur, crc_upd, crc_new, angle_new;
  logic [7:0]       dir_new, crc_lo_new;
  logic             fire, last_byte;

  assign in_ready_o  = !out_valid_q || out_ready_i || (pos_q < LastPos);
  assign fire        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // frame_start clears the frame before this byte is taken
  assign pos_cur = in_data_i.frame_start ? '0 : pos_q;
  assign crc_cur = in_data_i.frame_start ? CRC_INIT : crc_q;

  erfc_crc16_byte u_crc (
    .crc_i  (crc_cur),
    .data_i (in_data_i.rx_byte),
    .crc_o  (crc_upd)
  );

  always_comb begin
    angle_new  = in_data_i.frame_start ? '0 : angle_q;
    dir_new    = in_data_i.frame_start ? '0 : dir_q;
    crc_lo_new = in_data_i.frame_start ? '0 : crc_lo_q;
    crc_new    = (pos_cur < CrcLoPos) ? crc_upd : crc_cur;
    if (pos_cur == POS_ANGLE_HI) angle_new[15:8] = in_data_i.rx_byte;
    if (pos_cur == POS_ANGLE_LO) angle_new[7:0]  = in_data_i.rx_byte;
    if (pos_cur == POS_DIR)      dir_new         = in_data_i.rx_byte;
    if (pos_cur == CrcLoPos)     crc_lo_new      = in_data_i.rx_byte;
    last_byte = (pos_cur >= LastPos);

    pos_d       = pos_q;
    crc_d       = crc_q;
    angle_d     = angle_q;
    dir_d       = dir_q;
    crc_lo_d    = crc_lo_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;

    if (fire) begin
      if (last_byte) begin
        out_valid_d          = 1'b1;
        out_data_d.crc_bad   = ({in_data_i.rx_byte, crc_lo_new} != crc_new);
        out_data_d.angle_raw = angle_new;
        out_data_d.direction = dir_new;
        // start the next frame on its own
        pos_d    = '0;
        crc_d    = CRC_INIT;
        angle_d  = '0;
        dir_d    = '0;
        crc_lo_d = '0;
      end else begin
        pos_d    = pos_cur + POS_W'(1);
        crc_d    = crc_new;
        angle_d  = angle_new;
        dir_d    = dir_new;
        crc_lo_d = crc_lo_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      crc_q       <= CRC_INIT;
      angle_q     <= '0;
      dir_q       <= '0;
      crc_lo_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      angle_q     <= angle_d;
      dir_q       <= dir_d;
      crc_lo_q    <= crc_lo_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

>>> hdl/erfc_crc16_byte.sv
// One-byte update of the reflected CRC-16 (poly 0xA001).
// Depends on erfc_pkg for the polynomial.
module erfc_crc16_byte (
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);
  import erfc_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, data_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

>>> hdl/erfc_checker.sv
// Port-level assertions for the encoder reply frame checker, and their bind.
// Depends on erfc_pkg and encoder_reply_frame_checker_unit.
module erfc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input erfc_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input erfc_pkg::out_t out_data_o
);
  import erfc_pkg::*;

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // input back-pressure only comes from a full, stalled output slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

  // a new result follows an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result without a request");

  // a frame-start byte never ends a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.frame_start
      |=> out_valid_o == $past(out_valid_o && !out_ready_i))
    else $error("result on a frame-start byte");

endmodule

bind encoder_reply_frame_checker_unit erfc_checker u_erfc_checker (.*);

>>> test/encoder_reply_frame_checker_unit_test.sv
// Testbench for encoder_reply_frame_checker_unit: byte requests in, frame results out.
// Depends on erfc_pkg and the block's RTL; a local frame tracker predicts each result.
`timescale 1ns / 1ps

module encoder_reply_frame_checker_unit_test;

  localparam int FRAME_LEN   = erfc_pkg::FRAME_BYTES_DEF;
  localparam int ITEM_TARGET = 650;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic           in_valid = 1'b0;
  logic           in_ready;
  erfc_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  erfc_pkg::out_t out_data;

  encoder_reply_frame_checker_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Frame tracker state
  logic [4:0]  frm_pos;
  logic [15:0] frm_crc;
  logic [15:0] frm_angle;
  logic [7:0]  frm_dir;
  logic [7:0]  frm_crc_lo;

  erfc_pkg::out_t reply_q[$];

  logic [7:0] frame_buf [FRAME_LEN];

  int fail_count  = 0;
  int items_sent  = 0;
  int idle_cycles = 0;
  bit gaps_en     = 1'b1;
  int burst_left  = 0;
  bit rx_stall_en = 1'b1;
  int rx_hold_len = 0;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int k;
    c = crc ^ {8'h00, b};
    for (k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ erfc_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic clear_tracker();
    frm_pos    = '0;
    frm_crc    = erfc_pkg::CRC_INIT;
    frm_angle  = '0;
    frm_dir    = '0;
    frm_crc_lo = '0;
  endtask

  task automatic track_byte(input erfc_pkg::in_t item);
    logic [15:0] rx_crc;
    erfc_pkg::out_t res;
    if (item.frame_start) clear_tracker();
    if (frm_pos < FRAME_LEN - 2) frm_crc = crc16_byte(frm_crc, item.rx_byte);
    if (frm_pos == erfc_pkg::POS_ANGLE_HI) frm_angle[15:8] = item.rx_byte;
    if (frm_pos == erfc_pkg::POS_ANGLE_LO) frm_angle[7:0] = item.rx_byte;
    if (frm_pos == erfc_pkg::POS_DIR) frm_dir = item.rx_byte;
    if (frm_pos == FRAME_LEN - 2) frm_crc_lo = item.rx_byte;
    if (frm_pos >= FRAME_LEN - 1) begin
      rx_crc        = {item.rx_byte, frm_crc_lo};
      res.crc_bad   = (rx_crc != frm_crc);
      res.angle_raw = frm_angle;
      res.direction = frm_dir;
      reply_q.push_back(res);
      clear_tracker();
    end else begin
      frm_pos = frm_pos + 5'd1;
    end
  endtask

  // Offer one request; after acceptance, close the burst with a gap if due.
  task automatic send_byte(input erfc_pkg::in_t item);
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    track_byte(item);
    items_sent++;
    if (gaps_en) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_frame(input bit start, input int count);
    erfc_pkg::in_t item;
    int i;
    for (i = 0; i < count; i++) begin
      item.rx_byte     = frame_buf[i];
      item.frame_start = start && (i == 0);
      send_byte(item);
    end
  endtask

  task automatic fill_random();
    int i;
    for (i = 0; i < FRAME_LEN; i++) frame_buf[i] = 8'($urandom_range(0, 255));
  endtask

  // Write the CRC of the payload into the last two bytes, low byte first.
  task automatic seal_frame();
    logic [15:0] c;
    int i;
    c = erfc_pkg::CRC_INIT;
    for (i = 0; i < FRAME_LEN - 2; i++) c = crc16_byte(c, frame_buf[i]);
    frame_buf[FRAME_LEN-2] = c[7:0];
    frame_buf[FRAME_LEN-1] = c[15:8];
  endtask

  task automatic corrupt_frame();
    int idx;
    idx = $urandom_range(0, FRAME_LEN - 1);
    frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (reply_q.size() != 0);
  endtask

  // Receiver: random ready runs, or a long hold-off when one is requested
  initial begin
    int run_left;
    bit run_val;
    run_left = 0;
    run_val  = 1'b1;
    forever begin
      @(posedge clk);
      if (rx_hold_len != 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
      end else if (!rx_stall_en) begin
        out_ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_val  = ($urandom_range(0, 3) != 0);
          run_left = $urandom_range(1, 8);
        end
        run_left--;
        out_ready <= run_val;
      end
    end
  end

  always @(posedge clk) begin
    erfc_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected result crc_bad=%b angle_raw=%h direction=%h",
                 $time, out_data.crc_bad, out_data.angle_raw, out_data.direction);
        fail_count++;
      end else begin
        want = reply_q.pop_front();
        if (out_data.crc_bad !== want.crc_bad) begin
          $display("%0t: crc_bad expected %b got %b", $time, want.crc_bad, out_data.crc_bad);
          fail_count++;
        end
        if (out_data.angle_raw !== want.angle_raw) begin
          $display("%0t: angle_raw expected %h got %h",
                   $time, want.angle_raw, out_data.angle_raw);
          fail_count++;
        end
        if (out_data.direction !== want.direction) begin
          $display("%0t: direction expected %h got %h",
                   $time, want.direction, out_data.direction);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a request
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, reply_q.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Good frame with every payload byte at its maximum
  task automatic test_max_value_frame();
    int i;
    for (i = 0; i < FRAME_LEN; i++) frame_buf[i] = 8'hFF;
    seal_frame();
    send_frame(1'b1, FRAME_LEN);
    wait_for_replies();
  endtask

  // Partial frame dropped by a start, then a frame with an all-zero payload and a bad CRC
  task automatic test_dropped_partial_frame();
    int i;
    fill_random();
    send_frame(1'b1, 5);
    for (i = 0; i < FRAME_LEN; i++) frame_buf[i] = 8'h00;
    seal_frame();
    frame_buf[FRAME_LEN-2] = ~frame_buf[FRAME_LEN-2];
    send_frame(1'b1, FRAME_LEN);
    wait_for_replies();
  endtask

  // Hold the receiver off while frames keep coming, so the input stalls
  task automatic test_output_backpressure();
    int n;
    gaps_en     = 1'b0;
    rx_hold_len = HOLD_CYCLES;
    for (n = 0; n < 3; n++) begin
      fill_random();
      seal_frame();
      send_frame(n == 0, FRAME_LEN);
    end
    gaps_en = 1'b1;
    wait_for_replies();
  endtask

  // Stop sending mid frame until all results are out, then finish the frame
  task automatic test_pause_until_drained();
    erfc_pkg::in_t item;
    int i;
    fill_random();
    seal_frame();
    send_frame(1'b1, FRAME_LEN);
    fill_random();
    seal_frame();
    for (i = 0; i < FRAME_LEN; i++) begin
      if (i == 9) wait_for_replies();
      item.rx_byte     = frame_buf[i];
      item.frame_start = 1'b0;
      send_byte(item);
    end
    wait_for_replies();
  endtask

  task automatic test_random_frames();
    erfc_pkg::in_t item;
    int pick;
    int n;
    int i;
    while (items_sent < ITEM_TARGET) begin
      gaps_en     = ($urandom_range(0, 3) != 0);
      rx_stall_en = ($urandom_range(0, 3) != 0);
      pick        = $urandom_range(0, 99);
      fill_random();
      seal_frame();
      if (pick < 70) begin
        if ($urandom_range(0, 9) < 3) corrupt_frame();
        send_frame(1'($urandom_range(0, 1)), FRAME_LEN);
      end else if (pick < 85) begin
        send_frame(1'b1, $urandom_range(1, FRAME_LEN - 1));
      end else begin
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++) begin
          item.rx_byte     = 8'($urandom_range(0, 255));
          item.frame_start = ($urandom_range(0, 3) == 0);
          send_byte(item);
        end
      end
    end
    gaps_en     = 1'b1;
    rx_stall_en = 1'b1;
    wait_for_replies();
  endtask

  initial begin
    clear_tracker();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_max_value_frame();
    test_dropped_partial_frame();
    test_output_backpressure();
    test_pause_until_drained();
    test_random_frames();

    repeat (10) @(posedge clk);
    if (reply_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, reply_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
